// ----- rtl/rmpq_pkg.sv -----
// Shared types and constants for the river meeting point query block.
`default_nettype none

package rmpq_pkg;

   localparam int NODE_W = 11;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic [1:0] RES_ZERO  = 2'd0;
   localparam logic [1:0] RES_NODE  = 2'd1;
   localparam logic [1:0] RES_FLOW  = 2'd2;
   localparam logic [1:0] RES_ABORT = 2'd3;

   typedef struct packed {
      logic              action;
      logic [NODE_W-1:0] entry_node;
      logic [NODE_W-1:0] entry_downstream;
      logic [NODE_W-1:0] first_node;
      logic [NODE_W-1:0] second_node;
   } rmpq_req_type;

   typedef struct packed {
      logic [NODE_W-1:0] meeting_node;
      logic              walk_aborted;
   } rmpq_rsp_type;

   typedef struct packed {
      logic       write_en;
      logic       start;
      logic       read_en;
      logic       step;
      logic       res_load;
      logic [1:0] res_sel;
      logic       out_load;
   } rmpq_cmd_type;

   typedef struct packed {
      logic any_zero;
      logic same;
      logic flow_eq;
      logic cap_hit;
   } rmpq_status_type;

endpackage

`default_nettype wire

// ----- rtl/rmpq_ctrl.sv -----
// Controller state machine that sequences loads and the table walk of a query.
`default_nettype none

module rmpq_ctrl
   import rmpq_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_action,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   input  wire rmpq_status_type status,
   output rmpq_cmd_type         cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_EVAL  = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       req_take;
   logic       out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.res_sel = RES_ZERO;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_action == ACT_LOAD) begin
                  cmd.write_en = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (status.any_zero) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_ZERO;
               state_in     = S_DONE;
            end else if (status.same) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_NODE;
               state_in     = S_DONE;
            end else begin
               cmd.read_en = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            if (status.flow_eq) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_FLOW;
               state_in     = S_DONE;
            end else if (status.cap_hit) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_ABORT;
               state_in     = S_DONE;
            end else begin
               cmd.step = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/rmpq_dpath.sv -----
// Datapath with the downstream table, the two walk pointers and the result registers.
`default_nettype none

module rmpq_dpath
   import rmpq_pkg::*;
#(
   parameter int MAX_NODES = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire rmpq_req_type req_data,
   input  wire rmpq_cmd_type cmd,
   output rmpq_status_type   status,
   output rmpq_rsp_type      rsp_data
);

   localparam int AW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int IW  = (AW > NODE_W) ? AW : NODE_W;
   localparam int CW  = $clog2(2 * MAX_NODES + 1);
   localparam logic [CW-1:0] CAP = CW'(2 * MAX_NODES);

   logic [NODE_W-1:0] table_mem [MAX_NODES];

   logic [NODE_W-1:0] p_ff, p_in;
   logic [NODE_W-1:0] q_ff, q_in;
   logic [CW-1:0]     moves_ff, moves_in;
   logic [NODE_W-1:0] rd_p_ff;
   logic [NODE_W-1:0] rd_q_ff;
   logic              p_rng_ff;
   logic              q_rng_ff;
   logic [NODE_W-1:0] res_node_ff;
   logic              res_abort_ff;
   logic [NODE_W-1:0] out_node_ff;
   logic              out_abort_ff;

   logic [IW-1:0]     wr_wide;
   logic [IW-1:0]     rp_wide;
   logic [IW-1:0]     rq_wide;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rp_addr;
   logic [AW-1:0]     rq_addr;
   logic              wr_rng;
   logic [NODE_W-1:0] fp;
   logic [NODE_W-1:0] fq;

   function automatic logic in_range(input logic [NODE_W-1:0] node);
      in_range = (node != '0) && (32'(node) <= 32'(MAX_NODES));
   endfunction

   assign wr_wide = IW'(req_data.entry_node) - IW'(1);
   assign rp_wide = IW'(p_ff) - IW'(1);
   assign rq_wide = IW'(q_ff) - IW'(1);
   assign wr_addr = wr_wide[AW-1:0];
   assign rp_addr = rp_wide[AW-1:0];
   assign rq_addr = rq_wide[AW-1:0];
   assign wr_rng  = in_range(req_data.entry_node);

   always_ff @(posedge clock) begin
      if (cmd.write_en && wr_rng) begin
         table_mem[wr_addr] <= req_data.entry_downstream;
      end
      if (cmd.read_en) begin
         rd_p_ff  <= table_mem[rp_addr];
         rd_q_ff  <= table_mem[rq_addr];
         p_rng_ff <= in_range(p_ff);
         q_rng_ff <= in_range(q_ff);
      end
   end

   assign fp = p_rng_ff ? rd_p_ff : '0;
   assign fq = q_rng_ff ? rd_q_ff : '0;

   assign status.any_zero = (p_ff == '0) || (q_ff == '0);
   assign status.same     = (p_ff == q_ff);
   assign status.flow_eq  = (fp == fq);
   assign status.cap_hit  = (moves_ff >= CAP);

   always_comb begin
      p_in     = p_ff;
      q_in     = q_ff;
      moves_in = moves_ff;
      if (cmd.start) begin
         p_in     = req_data.first_node;
         q_in     = req_data.second_node;
         moves_in = '0;
      end else if (cmd.step) begin
         if (fp < fq) begin
            q_in = fq;
         end else begin
            p_in = fp;
         end
         moves_in = moves_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      p_ff     <= p_in;
      q_ff     <= q_in;
      moves_ff <= moves_in;
      if (cmd.res_load) begin
         case (cmd.res_sel)
            RES_NODE: begin
               res_node_ff  <= p_ff;
               res_abort_ff <= 1'b0;
            end
            RES_FLOW: begin
               res_node_ff  <= fp;
               res_abort_ff <= 1'b0;
            end
            RES_ABORT: begin
               res_node_ff  <= '0;
               res_abort_ff <= 1'b1;
            end
            default: begin
               res_node_ff  <= '0;
               res_abort_ff <= 1'b0;
            end
         endcase
      end
      if (cmd.out_load) begin
         out_node_ff  <= res_node_ff;
         out_abort_ff <= res_abort_ff;
      end
      if (reset) begin
         moves_ff <= '0;
      end
   end

   assign rsp_data.meeting_node = out_node_ff;
   assign rsp_data.walk_aborted = out_abort_ff;

endmodule

`default_nettype wire

// ----- rtl/river_meeting_point_query_top.sv -----
// Top level of the river meeting point query block.
`default_nettype none

// A load request writes one downstream table entry if its node is in 1 to MAX_NODES;
// loads are taken back to back while the block is idle. A query request walks the table
// with one registered lookup of both pointers per step, alternating check and evaluate,
// and aborts when its move count reaches the step cap of 2 * MAX_NODES. The block takes
// no new request while a query walks or while its result waits for the output register to free up.
// The table holds no reset value; every entry a walk reads must have been loaded first.
module river_meeting_point_query_top
   import rmpq_pkg::*;
#(
   parameter int MAX_NODES = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire rmpq_req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rmpq_rsp_type      rsp_data
);

   rmpq_cmd_type    cmd;
   rmpq_status_type status;

   rmpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   rmpq_dpath #(
      .MAX_NODES (MAX_NODES)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

`ifndef SYNTHESIS
   a_abort_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.walk_aborted |-> rsp_data.meeting_node == '0)
      else $error("aborted response carries a nonzero node");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.action == ACT_QUERY |=> req_stall)
      else $error("accepted query did not make the block busy");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_valid || !rsp_stall)
      else $error("result loaded over a stalled response");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_river_meeting_point_query_top.sv -----
// Self-checking testbench for the river meeting point query block.
`timescale 1ns / 1ps

module tb_river_meeting_point_query_top;
   import rmpq_pkg::*;

   localparam int NODES         = 1024;
   localparam int MOVE_CAP      = 2 * NODES;
   localparam int NODE_MAX_CODE = (1 << NODE_W) - 1;
   localparam int RANDOM_COUNT  = 600;
   localparam int HOLD_AT       = 200;
   localparam int DRAIN_AT      = 350;
   localparam int QUIET_FROM    = 520;
   localparam int LONG_HOLD     = 250;
   localparam int SETTLE_CYCLES = 40;
   localparam int IDLE_LIMIT    = 20000;

   typedef struct packed {
      rmpq_req_type req;
      logic         typed;
      rmpq_rsp_type rsp;
   } stim_row_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   rmpq_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rmpq_rsp_type rsp_data;

   logic [NODE_W-1:0] downstream_map [1:NODES];
   bit                loaded [1:NODES];
   int                loaded_nodes [$];
   rmpq_rsp_type      meeting_q [$];
   stim_row_type      directed_rows [$];
   rmpq_rsp_type      oldest_expected;

   bit hold_off_request = 1'b0;
   bit quiet_tail       = 1'b0;
   int error_count      = 0;
   int idle_cycles      = 0;
   int load_count       = 0;
   int query_count      = 0;
   int meet_count       = 0;
   int sea_count        = 0;
   int abort_count      = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   river_meeting_point_query_top #(
      .MAX_NODES(NODES)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // Walks both rivers downstream over the predicted table. The walk stops early and
   // flags the query when it would read an entry that was never loaded.
   function automatic rmpq_rsp_type walk_to_meeting(input logic [NODE_W-1:0] first_start,
                                                    input logic [NODE_W-1:0] second_start,
                                                    output bit reads_unloaded);
      logic [NODE_W-1:0] p;
      logic [NODE_W-1:0] q;
      logic [NODE_W-1:0] p_down;
      logic [NODE_W-1:0] q_down;
      rmpq_rsp_type      answer;
      int                moves;
      bit                done;
      p = first_start;
      q = second_start;
      answer = '0;
      moves = 0;
      done = 1'b0;
      reads_unloaded = 1'b0;
      while (!done) begin
         if (p == '0 || q == '0) begin
            done = 1'b1;
         end else if (p == q) begin
            answer.meeting_node = p;
            done = 1'b1;
         end else if ((p <= NODES && !loaded[p]) || (q <= NODES && !loaded[q])) begin
            reads_unloaded = 1'b1;
            done = 1'b1;
         end else begin
            p_down = (p <= NODES) ? downstream_map[p] : '0;
            q_down = (q <= NODES) ? downstream_map[q] : '0;
            if (p_down == q_down) begin
               answer.meeting_node = p_down;
               done = 1'b1;
            end else if (moves >= MOVE_CAP) begin
               answer.walk_aborted = 1'b1;
               done = 1'b1;
            end else begin
               if (p_down < q_down) begin
                  q = q_down;
               end else begin
                  p = p_down;
               end
               moves++;
            end
         end
      end
      return answer;
   endfunction

   function automatic stim_row_type stim_row(input logic action, input int entry_node,
                                             input int entry_down, input int a_node,
                                             input int b_node, input logic typed,
                                             input int meet, input logic aborted);
      stim_row_type row;
      row = '0;
      row.req.action           = action;
      row.req.entry_node       = NODE_W'(entry_node);
      row.req.entry_downstream = NODE_W'(entry_down);
      row.req.first_node       = NODE_W'(a_node);
      row.req.second_node      = NODE_W'(b_node);
      row.typed                = typed;
      row.rsp.meeting_node     = NODE_W'(meet);
      row.rsp.walk_aborted     = aborted;
      return row;
   endfunction

   function automatic int any_loaded_node();
      return loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
   endfunction

   task automatic offer_request(input rmpq_req_type item, input logic typed,
                                input rmpq_rsp_type typed_rsp, input bit allow_gap);
      int           gap;
      bit           unclean;
      rmpq_rsp_type predicted;
      gap = (allow_gap && $urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (item.action == ACT_LOAD) begin
         if (item.entry_node != '0 && item.entry_node <= NODES) begin
            if (!loaded[item.entry_node]) begin
               loaded_nodes.push_back(int'(item.entry_node));
            end
            loaded[item.entry_node] = 1'b1;
            downstream_map[item.entry_node] = item.entry_downstream;
            load_count++;
         end
      end else begin
         query_count++;
         if (typed) begin
            meeting_q.push_back(typed_rsp);
         end else begin
            predicted = walk_to_meeting(item.first_node, item.second_node, unclean);
            meeting_q.push_back(predicted);
         end
      end
   endtask

   initial begin
      rmpq_req_type item;
      rmpq_rsp_type guess;
      bit           unclean;
      bit           held;
      bit           drained;
      bit           ignored;
      int           issued;
      int           tries;
      int           pick;
      int           aborts_left;
      int           d;

      issued = 0;
      aborts_left = 3;
      held = 1'b0;
      drained = 1'b0;

      directed_rows.push_back(stim_row(ACT_QUERY, 0, 0, 0, 0, 1'b1, 0, 1'b0));
      directed_rows.push_back(stim_row(ACT_QUERY, 0, 0, 0, NODE_MAX_CODE, 1'b1, 0, 1'b0));
      directed_rows.push_back(stim_row(ACT_QUERY, 0, 0, NODE_MAX_CODE, NODE_MAX_CODE,
                                       1'b1, NODE_MAX_CODE, 1'b0));
      directed_rows.push_back(stim_row(ACT_QUERY, 0, 0, NODES, 0, 1'b1, 0, 1'b0));
      directed_rows.push_back(stim_row(ACT_LOAD, 1, 3, 0, 0, 1'b0, 0, 1'b0));
      directed_rows.push_back(stim_row(ACT_LOAD, 2, 3, 0, 0, 1'b0, 0, 1'b0));
      directed_rows.push_back(stim_row(ACT_LOAD, 3, 0, 0, 0, 1'b0, 0, 1'b0));
      directed_rows.push_back(stim_row(ACT_QUERY, 0, 0, 1, 2, 1'b1, 3, 1'b0));
      directed_rows.push_back(stim_row(ACT_QUERY, 0, 0, 1, 3, 1'b0, 0, 1'b0));
      directed_rows.push_back(stim_row(ACT_QUERY, 0, 0, 3, 3, 1'b1, 3, 1'b0));
      directed_rows.push_back(stim_row(ACT_LOAD, 5, 6, 0, 0, 1'b0, 0, 1'b0));
      directed_rows.push_back(stim_row(ACT_LOAD, 6, 5, 0, 0, 1'b0, 0, 1'b0));
      directed_rows.push_back(stim_row(ACT_LOAD, 7, 7, 0, 0, 1'b0, 0, 1'b0));
      directed_rows.push_back(stim_row(ACT_QUERY, 0, 0, 5, 7, 1'b1, 0, 1'b1));
      directed_rows.push_back(stim_row(ACT_LOAD, NODES, NODE_MAX_CODE, 0, 0, 1'b0, 0, 1'b0));
      directed_rows.push_back(stim_row(ACT_LOAD, NODES - 1, NODES, 0, 0, 1'b0, 0, 1'b0));
      directed_rows.push_back(stim_row(ACT_QUERY, 0, 0, NODES - 1, 1, 1'b0, 0, 1'b0));
      directed_rows.push_back(stim_row(ACT_LOAD, 0, 5, 0, 0, 1'b0, 0, 1'b0));
      directed_rows.push_back(stim_row(ACT_LOAD, NODE_MAX_CODE, 1, 0, 0, 1'b0, 0, 1'b0));
      directed_rows.push_back(stim_row(ACT_LOAD, NODES + 1, 0, 0, 0, 1'b0, 0, 1'b0));
      directed_rows.push_back(stim_row(ACT_QUERY, 0, 0, 2, 1, 1'b0, 0, 1'b0));
      directed_rows.push_back(stim_row(ACT_QUERY, 0, 0, NODES + 1, NODES + 2, 1'b0, 0, 1'b0));
      directed_rows.push_back(stim_row(ACT_LOAD, 8, 0, 0, 0, 1'b0, 0, 1'b0));
      directed_rows.push_back(stim_row(ACT_LOAD, 9, 0, 0, 0, 1'b0, 0, 1'b0));
      directed_rows.push_back(stim_row(ACT_QUERY, 0, 0, 8, 9, 1'b0, 0, 1'b0));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp, 1'b1);
      end

      while (issued < RANDOM_COUNT) begin
         if (issued >= HOLD_AT && !held) begin
            held = 1'b1;
            hold_off_request = 1'b1;
         end
         if (issued >= DRAIN_AT && !drained) begin
            drained = 1'b1;
            @(negedge clock);
            req_valid <= 1'b0;
            while (meeting_q.size() != 0) @(posedge clock);
         end
         quiet_tail = (issued >= QUIET_FROM);

         item = '0;
         item.entry_node       = NODE_W'($urandom_range(0, NODE_MAX_CODE));
         item.entry_downstream = NODE_W'($urandom_range(0, NODE_MAX_CODE));
         item.first_node       = NODE_W'($urandom_range(0, NODE_MAX_CODE));
         item.second_node      = NODE_W'($urandom_range(0, NODE_MAX_CODE));
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            // Tree growth: a node flows into a higher-numbered loaded node, or straight into the sea.
            item.action = ACT_LOAD;
            d = (loaded_nodes.size() == 0 || $urandom_range(0, 4) == 0) ? 0 : any_loaded_node();
            if (d < 2) begin
               item.entry_node       = NODE_W'($urandom_range(1, NODES));
               item.entry_downstream = '0;
            end else begin
               item.entry_node       = NODE_W'($urandom_range(d > 40 ? d - 40 : 1, d - 1));
               item.entry_downstream = NODE_W'(d);
            end
         end else if (pick < 48) begin
            item.action = ACT_LOAD;
         end else begin
            item.action = ACT_QUERY;
            tries = 0;
            do begin
               pick = $urandom_range(0, 99);
               if (pick < 85 && loaded_nodes.size() != 0) begin
                  item.first_node = NODE_W'(any_loaded_node());
               end else begin
                  item.first_node = NODE_W'($urandom_range(0, NODE_MAX_CODE));
               end
               if (pick < 70 && loaded_nodes.size() != 0) begin
                  item.second_node = NODE_W'(any_loaded_node());
               end else begin
                  item.second_node = NODE_W'($urandom_range(0, NODE_MAX_CODE));
               end
               guess = walk_to_meeting(item.first_node, item.second_node, unclean);
               tries++;
            end while ((unclean || (guess.walk_aborted && aborts_left == 0)) && tries < 30);
            if (unclean || (guess.walk_aborted && aborts_left == 0)) begin
               item.first_node = '0;
            end else if (guess.walk_aborted) begin
               aborts_left--;
            end
         end

         ignored = (item.action == ACT_LOAD) &&
                   (item.entry_node == '0 || item.entry_node > NODES);
         offer_request(item, 1'b0, '0, !quiet_tail);
         if (!ignored) begin
            issued++;
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (meeting_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d table loads and %0d queries.", load_count, query_count);
      $display("Queries met at a node %0d times, reached the sea %0d times, aborted %0d times.",
               meet_count, sea_count, abort_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7) - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (meeting_q.size() == 0) begin
            error_count++;
            $error("meeting_node: expected no result, actual %0d", rsp_data.meeting_node);
         end else begin
            oldest_expected = meeting_q.pop_front();
            if (rsp_data.meeting_node !== oldest_expected.meeting_node) begin
               error_count++;
               $error("meeting_node: expected %0d, actual %0d",
                      oldest_expected.meeting_node, rsp_data.meeting_node);
            end
            if (rsp_data.walk_aborted !== oldest_expected.walk_aborted) begin
               error_count++;
               $error("walk_aborted: expected %0d, actual %0d",
                      oldest_expected.walk_aborted, rsp_data.walk_aborted);
            end
            if (oldest_expected.walk_aborted) begin
               abort_count++;
            end else if (oldest_expected.meeting_node == '0) begin
               sea_count++;
            end else begin
               meet_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && rsp_stall == 1'b0)) begin
         idle_cycles = 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles++;
      end
   end

endmodule
